// ===== src/efws_pkg.sv =====
package efws_pkg;

    localparam int CFG_W  = 5;
    localparam int DUR_W  = 32;
    localparam int TIME_W = 63;
    localparam int WIDX_W = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_UPDATE
    } efws_state_t;

    typedef struct packed {
        logic              valid;
        logic [WIDX_W-1:0] worker_index;
        logic [TIME_W-1:0] start_time;
    } efws_result_t;

endpackage

// ===== src/efws_time_mem.sv =====
module efws_time_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [AW-1:0]               rd_addr,
    output logic [efws_pkg::TIME_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [efws_pkg::TIME_W-1:0] wr_data
);
    import efws_pkg::*;

    logic [TIME_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [TIME_W-1:0] rd_data_reg;

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_reg[rd_addr])
        begin
            rd_data_reg <= mem[rd_addr];
        end
        else
        begin
            rd_data_reg <= '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/efws_core.sv =====
module efws_core #(
    parameter int MAX_WORKERS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [efws_pkg::CFG_W-1:0]   workers_in_use,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [efws_pkg::DUR_W-1:0]   job_duration,
    input  logic                         slot_free,
    output efws_pkg::efws_result_t       result
);
    import efws_pkg::*;

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CAP   = (MAX_WORKERS < 31) ? MAX_WORKERS : 31;

    efws_state_t       state_reg, state_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [CFG_W-1:0]  n_reg, n_next;
    logic [CFG_W-1:0]  cnt_reg, cnt_next;
    logic [CFG_W-1:0]  started_reg, started_next;
    logic              first_reg, first_next;
    logic [TIME_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [IDX_W-1:0]  prev_idx_reg;

    logic [CFG_W-1:0]  n_in;
    logic              fill;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_data;
    logic              take;
    logic [TIME_W:0]   sum_full;
    logic [TIME_W-1:0] sum_sat;
    logic              wr_en;

    always_comb
    begin
        if (workers_in_use == '0)
        begin
            n_in = CFG_W'(1);
        end
        else if (workers_in_use > CFG_W'(CAP))
        begin
            n_in = CFG_W'(CAP);
        end
        else
        begin
            n_in = workers_in_use;
        end
    end

    assign fill     = started_reg < n_in;
    assign in_ready = (state_reg == ST_IDLE);
    assign take     = first_reg || (rd_data < best_val_reg);
    assign sum_full = {1'b0, best_val_reg} + (TIME_W + 1)'(dur_reg);
    assign sum_sat  = sum_full[TIME_W] ? TIME_MAX : sum_full[TIME_W-1:0];
    assign wr_en    = (state_reg == ST_UPDATE) && slot_free;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = fill ? IDX_W'(started_reg) : '0;
            end
            ST_SCAN:
            begin
                rd_addr = IDX_W'(cnt_reg);
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    efws_time_mem #(
        .DEPTH (MAX_WORKERS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (best_idx_reg),
        .wr_data (sum_sat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (fill || n_in == CFG_W'(1))
                    begin
                        state_next = ST_LAST;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == n_reg - CFG_W'(1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dur_next      = dur_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        started_next  = started_reg;
        first_next    = first_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dur_next   = job_duration;
                    n_next     = n_in;
                    cnt_next   = CFG_W'(1);
                    first_next = 1'b1;
                    if (fill)
                    begin
                        started_next = started_reg + CFG_W'(1);
                    end
                end
            end
            ST_SCAN, ST_LAST:
            begin
                cnt_next   = cnt_reg + CFG_W'(1);
                first_next = 1'b0;
                if (take)
                begin
                    best_val_next = rd_data;
                    best_idx_next = prev_idx_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= '0;
            first_reg   <= 1'b0;
            cnt_reg     <= '0;
            n_reg       <= CFG_W'(1);
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            first_reg   <= first_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_reg      <= dur_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        prev_idx_reg <= rd_addr;
    end

    always_comb
    begin
        result.valid        = wr_en;
        result.worker_index = WIDX_W'(best_idx_reg);
        result.start_time   = best_val_reg;
    end

endmodule

// ===== src/earliest_free_worker_scheduler.sv =====
// channel   | dir | tdata (low bit up)                     | note
// s_axis    | in  | job_duration[31:0]                     | one job per beat
// m_axis    | out | worker_index[3:0], start_time[66:4]    | one beat per job
// cfg       | in  | workers_in_use[4:0]                    | write-only, reset 16
//
// With all n workers busy a job occupies the block for one finish-time read per
// cycle through a single comparator, then one saturating add and write-back; its
// beat is registered onto m_axis at the write-back.
// While unstarted workers remain, or with one worker, a job reads only one finish
// time before the add and write-back.
// Reset clears finish times, started count and output valid.
// A result waiting on m_axis holds the write-back until it is taken.
module earliest_free_worker_scheduler #(
    parameter int MAX_WORKERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // job_duration[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // worker_index[3:0], start_time[66:4], zero[71:67]
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data     // workers_in_use[4:0]
);
    import efws_pkg::*;

    logic [CFG_W-1:0]  cfg_reg;
    logic              out_valid_reg;
    logic [WIDX_W-1:0] out_idx_reg;
    logic [TIME_W-1:0] out_time_reg;
    logic              slot_free;
    efws_result_t      result;

    assign slot_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_W'(16);
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_wr_data;
        end
    end

    efws_core #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .workers_in_use (cfg_reg),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .job_duration   (s_axis_tdata),
        .slot_free      (slot_free),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_idx_reg  <= result.worker_index;
            out_time_reg <= result.start_time;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_time_reg, out_idx_reg};

endmodule
